// ===== rtl/core/tsr_pkg.sv =====
// Shared definitions for the triangle span rasterizer: coordinate width,
// operation codes and the command and response payload structs.
// No dependencies.
`default_nettype none

package tsr_pkg;

    localparam int COORD_BITS = 12;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    typedef struct packed {
        logic                          op;
        logic signed [COORD_BITS-1:0] vertex_a_x;
        logic signed [COORD_BITS-1:0] vertex_a_y;
        logic signed [COORD_BITS-1:0] vertex_b_x;
        logic signed [COORD_BITS-1:0] vertex_b_y;
        logic signed [COORD_BITS-1:0] vertex_c_x;
        logic signed [COORD_BITS-1:0] vertex_c_y;
    } tsr_cmd_t;

    typedef struct packed {
        logic                          has_pixel;
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                          finished;
    } tsr_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/tsr_div.sv =====
// Restoring divider, one quotient bit per cycle, for the edge interpolation.
// Stand-alone; the caller guarantees that the quotient fits in W bits.
`default_nettype none

module tsr_div #(
    parameter int W = 12
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [2*W-1:0] num,
    input  wire logic [W-1:0]   den,
    output logic                done,
    output logic [W-1:0]        quot
);

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       shifted;
    logic [W:0]       trial;

    always_comb
    begin
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, acc_reg[W-1]};
        trial     = shifted - {1'b0, den_reg};
        if (start)
        begin
            // The upper half of the dividend is already below the divisor.
            rem_next  = num[2*W-1:W];
            acc_next  = num[W-1:0];
            den_next  = den;
            cnt_next  = CNT_W'(W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                acc_next = {acc_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                acc_next = {acc_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            acc_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            acc_reg  <= acc_next;
            den_reg  <= den_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/core/triangle_span_rasterizer.sv =====
// Scanline triangle filler: a load command takes three vertices, and every
// next command returns the following covered pixel. Depends on tsr_pkg and tsr_div.
// Top level of the block.
`default_nettype none

// The block takes one command transfer at a time and answers each with exactly
// one response transfer. A load sorts the three vertices by y with three
// strict compare-swaps (one per cycle, the last one held until the output
// register is free) and answers with an all-zero response. A next command
// that falls inside a span answers straight from the step state. When a new
// row must be set up, both edge positions are interpolated by the one shared
// multiplier and the one shared divider, which yields one quotient bit per
// cycle; each edge passes through the set-up, multiply, divider-start and
// divide states, except the first edge on the row of the middle vertex, which
// is taken directly. An empty row is set up in the same way and then skipped.
// Once the triangle is exhausted, or before any load, a next command answers
// with finished set. A new command is taken whenever the sequencer is idle,
// even while the previous response still waits in the output register; the
// response of a command waits until that register is free.
module triangle_span_rasterizer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_stall,
    input  wire tsr_pkg::tsr_cmd_t cmd,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output tsr_pkg::tsr_rsp_t     rsp
);

    localparam int CB = tsr_pkg::COORD_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_AB,
        S_SORT_AC,
        S_SORT_BC,
        S_STEP,
        S_SETUP,
        S_MUL,
        S_START,
        S_DIV
    } state_t;

    state_t state_reg, state_next;

    // Sorted vertices: index 0 is the top, 1 the middle and 2 the bottom.
    logic signed [CB-1:0] vx_reg [3];
    logic signed [CB-1:0] vx_next [3];
    logic signed [CB-1:0] vy_reg [3];
    logic signed [CB-1:0] vy_next [3];

    logic signed [CB-1:0] row_reg, row_next;
    logic signed [CB-1:0] col_reg, col_next;
    logic signed [CB-1:0] end_reg, end_next;
    logic signed [CB-1:0] e1_reg, e1_next;
    logic signed [CB-1:0] x0_reg, x0_next;
    logic signed [CB:0]   dx_reg, dx_next;
    logic [CB-1:0]        dy_reg, dy_next;
    logic [CB-1:0]        den_reg, den_next;
    logic signed [2*CB+1:0] prod_reg, prod_next;
    logic                 span_reg, span_next;
    logic                 tri_reg, tri_next;
    logic                 edge_reg, edge_next;

    tsr_pkg::tsr_rsp_t    rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic                 div_start;
    logic                 div_done;
    logic [CB-1:0]        div_quot;
    logic                 prod_neg;
    logic signed [2*CB+1:0] prod_abs;

    assign prod_neg = prod_reg[2*CB+1];
    assign prod_abs = prod_neg ? -prod_reg : prod_reg;

    tsr_div #(
        .W (CB)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_abs[2*CB-1:0]),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        logic                 slot_free;
        logic signed [CB-1:0] sx0;
        logic signed [CB-1:0] sx1;
        logic signed [CB-1:0] sy0;
        logic signed [CB-1:0] sy1;
        logic signed [CB:0]   dy_full;
        logic signed [CB:0]   den_full;
        logic signed [CB:0]   q_mag;
        logic signed [CB:0]   q_s;
        logic signed [CB:0]   e_sum;
        logic signed [CB-1:0] e_val;

        state_next     = state_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        end_next       = end_reg;
        e1_next        = e1_reg;
        x0_next        = x0_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        den_next       = den_reg;
        prod_next      = prod_reg;
        span_next      = span_reg;
        tri_next       = tri_reg;
        edge_next      = edge_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        div_start      = 1'b0;

        slot_free = !rsp_valid_reg || !rsp_stall;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        // Edge selection for the interpolation set-up.
        sx0 = vx_reg[0];
        sx1 = vx_reg[2];
        sy0 = vy_reg[0];
        sy1 = vy_reg[2];
        if (!edge_reg)
        begin
            if (row_reg < vy_reg[1])
            begin
                sx1 = vx_reg[1];
                sy1 = vy_reg[1];
            end
            else
            begin
                sx0 = vx_reg[1];
                sy0 = vy_reg[1];
            end
        end
        dy_full  = {row_reg[CB-1], row_reg} - {sy0[CB-1], sy0};
        den_full = {sy1[CB-1], sy1} - {sy0[CB-1], sy0};

        // Signed quotient added back onto the edge start; it always fits.
        q_mag = {1'b0, div_quot};
        q_s   = prod_neg ? -q_mag : q_mag;
        e_sum = {x0_reg[CB-1], x0_reg} + q_s;
        e_val = e_sum[CB-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == tsr_pkg::OP_LOAD)
                    begin
                        vx_next[0] = cmd.vertex_a_x;
                        vy_next[0] = cmd.vertex_a_y;
                        vx_next[1] = cmd.vertex_b_x;
                        vy_next[1] = cmd.vertex_b_y;
                        vx_next[2] = cmd.vertex_c_x;
                        vy_next[2] = cmd.vertex_c_y;
                        state_next = S_SORT_AB;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
            end
            S_SORT_AB:
            begin
                if (vy_reg[0] > vy_reg[1])
                begin
                    vx_next[0] = vx_reg[1];
                    vy_next[0] = vy_reg[1];
                    vx_next[1] = vx_reg[0];
                    vy_next[1] = vy_reg[0];
                end
                state_next = S_SORT_AC;
            end
            S_SORT_AC:
            begin
                if (vy_reg[0] > vy_reg[2])
                begin
                    vx_next[0] = vx_reg[2];
                    vy_next[0] = vy_reg[2];
                    vx_next[2] = vx_reg[0];
                    vy_next[2] = vy_reg[0];
                end
                state_next = S_SORT_BC;
            end
            S_SORT_BC:
            begin
                if (slot_free)
                begin
                    if (vy_reg[1] > vy_reg[2])
                    begin
                        vx_next[1] = vx_reg[2];
                        vy_next[1] = vy_reg[2];
                        vx_next[2] = vx_reg[1];
                        vy_next[2] = vy_reg[1];
                    end
                    row_next       = vy_reg[0];
                    col_next       = '0;
                    end_next       = '0;
                    span_next      = 1'b0;
                    tri_next       = 1'b1;
                    rsp_next       = '0;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_STEP:
            begin
                if (!tri_reg)
                begin
                    if (slot_free)
                    begin
                        rsp_next       = '0;
                        rsp_next.finished = 1'b1;
                        rsp_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (span_reg)
                begin
                    if (col_reg < end_reg)
                    begin
                        if (slot_free)
                        begin
                            rsp_next.has_pixel = 1'b1;
                            rsp_next.pixel_x   = col_reg;
                            rsp_next.pixel_y   = row_reg;
                            rsp_next.finished  = 1'b0;
                            rsp_valid_next     = 1'b1;
                            col_next           = col_reg + CB'(1);
                            state_next         = S_IDLE;
                        end
                    end
                    else
                    begin
                        span_next = 1'b0;
                        row_next  = row_reg + CB'(1);
                    end
                end
                else if (row_reg >= vy_reg[2])
                begin
                    tri_next = 1'b0;
                end
                else
                begin
                    edge_next  = 1'b0;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (!edge_reg && (row_reg == vy_reg[1]))
                begin
                    // The middle row takes the middle vertex x directly.
                    e1_next   = vx_reg[1];
                    edge_next = 1'b1;
                end
                else
                begin
                    x0_next    = sx0;
                    dx_next    = {sx1[CB-1], sx1} - {sx0[CB-1], sx0};
                    dy_next    = dy_full[CB-1:0];
                    den_next   = den_full[CB-1:0];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = (2*CB+2)'(dx_reg) * (2*CB+2)'($signed({1'b0, dy_reg}));
                state_next = S_START;
            end
            S_START:
            begin
                // The product is registered now, so the divider can take it.
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (!edge_reg)
                    begin
                        e1_next    = e_val;
                        edge_next  = 1'b1;
                        state_next = S_SETUP;
                    end
                    else
                    begin
                        if (e1_reg > e_val)
                        begin
                            col_next = e_val;
                            end_next = e1_reg;
                        end
                        else
                        begin
                            col_next = e1_reg;
                            end_next = e_val;
                        end
                        span_next  = 1'b1;
                        state_next = S_STEP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vx_reg        <= '{default: '0};
            vy_reg        <= '{default: '0};
            row_reg       <= '0;
            col_reg       <= '0;
            end_reg       <= '0;
            e1_reg        <= '0;
            x0_reg        <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            den_reg       <= '0;
            prod_reg      <= '0;
            span_reg      <= 1'b0;
            tri_reg       <= 1'b0;
            edge_reg      <= 1'b0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vx_reg        <= vx_next;
            vy_reg        <= vy_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            end_reg       <= end_next;
            e1_reg        <= e1_next;
            x0_reg        <= x0_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            den_reg       <= den_next;
            prod_reg      <= prod_next;
            span_reg      <= span_next;
            tri_reg       <= tri_next;
            edge_reg      <= edge_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Commands are taken only while the sequencer is idle.
    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
